### design/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg: shared definitions for the positional array list
// Sizes, command and status codes and sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  localparam int DEPTH      = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(DEPTH + 1);

  localparam int CMD_W   = 3;
  localparam int POS_W   = 7;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_OUT_W = 7;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REM_END   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REM_POS   = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MOVE = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

`default_nettype wire

### design/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list: ordered list with insert and remove at any index
// Word store in a single-port-write, single-port-read memory, shifted by a
// small sequencer one entry per cycle.
// ----------------------------------------------------------------------------
// One command is taken at a time; in_stall stays high until the command has
// finished its work. Each stored entry that a command moves (counting the
// removed entry itself for a removal) passes through the entry store, which
// gives one read and one write per cycle: each moved entry is read at one
// address and written back one place up or down. An insert at the end moves
// nothing. Rejected commands (full, empty, bad position) and unused codes go
// straight to the result without a move phase. The result word sits in an
// output register, so a new command can be taken while it waits on out_stall.
`default_nettype none

module positional_array_list (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [pal_pkg::CMD_W-1:0]      command,
  input  wire logic [pal_pkg::POS_W-1:0]      position,
  input  wire logic [pal_pkg::WORD_W-1:0]     element,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pal_pkg::WORD_W-1:0]          removed_element,
  output logic [pal_pkg::STAT_W-1:0]          status,
  output logic [pal_pkg::CNT_OUT_W-1:0]       entry_count
);

  localparam int AW = pal_pkg::ADDR_W;
  localparam int CW = pal_pkg::COUNT_W;
  localparam int EW = pal_pkg::ELEM_WIDTH;

  pal_pkg::state_t state;

  logic [EW-1:0] mem [pal_pkg::DEPTH];
  logic [EW-1:0] rdata;

  logic [CW-1:0]     total;
  logic [CW-1:0]     rd_left;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     rd_src;
  logic              rd_vld_q;
  logic              ins;
  logic [AW-1:0]     at;
  logic [EW-1:0]     elem;
  logic [EW-1:0]     removed;
  logic [pal_pkg::STAT_W-1:0] res_status;

  // command decode
  logic                       dec_ins;
  logic                       dec_rem;
  logic [31:0]                dec_at32;
  logic [pal_pkg::STAT_W-1:0] dec_status;
  logic                       dec_go;

  always_comb begin
    dec_ins    = (command <= pal_pkg::CMD_INS_POS);
    dec_rem    = !dec_ins && (command <= pal_pkg::CMD_REM_POS);
    dec_at32   = 32'(position);
    dec_status = pal_pkg::ST_DONE;
    case (command)
      pal_pkg::CMD_INS_FRONT: dec_at32 = 32'd0;
      pal_pkg::CMD_INS_END:   dec_at32 = 32'(total);
      pal_pkg::CMD_REM_FRONT: dec_at32 = 32'd0;
      pal_pkg::CMD_REM_END:   dec_at32 = 32'(total) - 32'd1;
      default:                dec_at32 = 32'(position);
    endcase
    if (dec_ins) begin
      if (32'(total) >= 32'(pal_pkg::DEPTH)) begin
        dec_status = pal_pkg::ST_FULL;
      end else if (dec_at32 > 32'(total)) begin
        dec_status = pal_pkg::ST_BADPOS;
      end
    end else if (dec_rem) begin
      if (total == '0) begin
        dec_status = pal_pkg::ST_EMPTY;
      end else if (dec_at32 >= 32'(total)) begin
        dec_status = pal_pkg::ST_BADPOS;
      end
    end
    dec_go = (dec_ins || dec_rem) && (dec_status == pal_pkg::ST_DONE);
  end

  assign in_stall = (state != pal_pkg::S_IDLE);

  // memory port control
  logic          re;
  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;

  always_comb begin
    re = (state == pal_pkg::S_MOVE) && (rd_left != '0);
    we = 1'b0;
    wa = at;
    wd = elem;
    if (state == pal_pkg::S_MOVE) begin
      if (rd_vld_q) begin
        // moved word: up one place on insert, down one on remove
        we = ins || (rd_src != at);
        wa = ins ? rd_src + AW'(1) : rd_src - AW'(1);
        wd = rdata;
      end else if (rd_left == '0) begin
        we = ins;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pal_pkg::S_IDLE;
      out_valid <= 1'b0;
      total     <= '0;
      rd_left   <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && !out_stall && (state != pal_pkg::S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        pal_pkg::S_IDLE: begin
          if (in_valid) begin
            res_status <= dec_status;
            removed    <= '0;
            ins        <= dec_ins;
            at         <= AW'(dec_at32);
            elem       <= EW'(element);
            rd_vld_q   <= 1'b0;
            if (dec_go) begin
              rd_left <= CW'(32'(total) - dec_at32);
              rd_addr <= dec_ins ? AW'(32'(total) - 32'd1) : AW'(dec_at32);
              state   <= pal_pkg::S_MOVE;
            end else begin
              state <= pal_pkg::S_DONE;
            end
          end
        end
        pal_pkg::S_MOVE: begin
          rd_vld_q <= re;
          rd_src   <= rd_addr;
          if (re) begin
            rd_left <= rd_left - CW'(1);
            rd_addr <= ins ? rd_addr - AW'(1) : rd_addr + AW'(1);
          end
          // first word read on a removal is the one taken out
          if (rd_vld_q && !ins && (rd_src == at)) begin
            removed <= rdata;
          end
          if ((rd_left == '0) && !rd_vld_q) begin
            total <= ins ? total + CW'(1) : total - CW'(1);
            state <= pal_pkg::S_DONE;
          end
        end
        pal_pkg::S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            removed_element <= pal_pkg::WORD_W'(removed);
            status          <= res_status;
            entry_count     <= pal_pkg::CNT_OUT_W'(total);
            state           <= pal_pkg::S_IDLE;
          end
        end
        default: begin
          state <= pal_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_read_in_move: assert property (@(posedge clk) disable iff (rst)
    rd_vld_q |-> (state == pal_pkg::S_MOVE))
    else $error("read data pending outside move phase");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != pal_pkg::S_IDLE))
    else $error("sequencer idle right after accepting a command");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(entry_count) <= 32'(pal_pkg::DEPTH)))
    else $error("entry count beyond list depth");

  a_err_no_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != pal_pkg::ST_DONE)) |-> (removed_element == '0))
    else $error("rejected command returned a word");
`endif

endmodule

`default_nettype wire
